>>> rtl/core/jcsg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register indexes of the JTAG scan sequence generator.
package jcsg_pkg;

   localparam int DATA_W          = 32;
   localparam int MAX_DEVICES_DEF = 32;
   localparam int DR_WIDTH_DEF    = 32;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int POS_W           = 9;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 8;

   localparam logic [7:0] IR_BITS_MAX = 8'd240;

   // Request kinds.
   localparam logic REQ_IR = 1'b0;
   localparam logic REQ_DR = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICES_BEFORE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICES_AFTER  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IR_BITS_BEFORE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IR_LEN_TARGET  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IR_BITS_AFTER  = 3'd4;

   // One classified scan, expressed as bit positions in the serial stream.
   typedef struct packed {
      logic [3:0]        head_tms;   // TMS pattern of the entry sequence
      logic [2:0]        body_start; // first shifted bit
      logic [POS_W-1:0]  mid_start;  // first target bit
      logic [POS_W-1:0]  mid_end;    // first bypass bit after the target
      logic [POS_W-1:0]  body_end;   // first exit bit
      logic [POS_W-1:0]  len_total;  // total bits including exit
      logic [DATA_W-1:0] data;
      logic              capture;
   } jcsg_cmd_type;

   typedef struct packed {
      logic         valid;
      jcsg_cmd_type cmd;
   } jcsg_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jcsg_qstat_type;

endpackage

>>> rtl/core/jcsg_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the JTAG scan sequence generator.
interface jcsg_req_if import jcsg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [7:0]        ir_value;
   logic [DATA_W-1:0] dr_data;
   logic [5:0]        dr_length;
   logic              capture_data;

   modport source (output valid, req_type, ir_value, dr_data, dr_length, capture_data,
                   input ready);
   modport sink (input valid, req_type, ir_value, dr_data, dr_length, capture_data,
                 output ready);
endinterface

interface jcsg_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] tms_byte;
   logic [7:0] tdi_byte;
   logic [7:0] read_mask;
   logic [3:0] bit_count;
   logic       last;

   modport source (output valid, tms_byte, tdi_byte, read_mask, bit_count, last,
                   input ready);
   modport sink (input valid, tms_byte, tdi_byte, read_mask, bit_count, last,
                 output ready);
endinterface

interface jcsg_csr_if import jcsg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/jcsg_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, request classification and repeat-IR filtering.
module jcsg_front import jcsg_pkg::*; #(
   parameter int MAX_DEVICES = MAX_DEVICES_DEF,
   parameter int DR_WIDTH    = DR_WIDTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   jcsg_req_if.sink       req,
   jcsg_csr_if.sink       csr,
   input  jcsg_qstat_type q_stat,
   output jcsg_push_type  q_push
);

   localparam logic [5:0] MAX_DEV_M1 = 6'(MAX_DEVICES - 1);
   localparam logic [6:0] DR_MAX     = 7'(DR_WIDTH);

   logic [4:0] devices_before_ff, devices_before_in;
   logic [4:0] devices_after_ff, devices_after_in;
   logic [7:0] ir_bits_before_ff, ir_bits_before_in;
   logic [3:0] ir_len_target_ff, ir_len_target_in;
   logic [7:0] ir_bits_after_ff, ir_bits_after_in;
   logic [7:0] last_instr_ff, last_instr_in;
   logic       instr_known_ff, instr_known_in;

   logic       accept;
   logic       skip;
   logic [7:0] ir_pre, ir_post;
   logic [3:0] ir_len;
   logic [5:0] dev_pre, dev_post, dev_post_max;
   logic [6:0] dr_len;
   jcsg_cmd_type cmd;

   assign csr.ready = 1'b1;
   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;
   assign skip      = (req.req_type == REQ_IR) && instr_known_ff
                      && (last_instr_ff == req.ir_value);

   always_comb begin
      devices_before_in = devices_before_ff;
      devices_after_in  = devices_after_ff;
      ir_bits_before_in = ir_bits_before_ff;
      ir_len_target_in  = ir_len_target_ff;
      ir_bits_after_in  = ir_bits_after_ff;
      if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_DEVICES_BEFORE: devices_before_in = csr.data[4:0];
            CSR_DEVICES_AFTER:  devices_after_in  = csr.data[4:0];
            CSR_IR_BITS_BEFORE: ir_bits_before_in = csr.data;
            CSR_IR_LEN_TARGET:  ir_len_target_in  = csr.data[3:0];
            CSR_IR_BITS_AFTER:  ir_bits_after_in  = csr.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      last_instr_in  = last_instr_ff;
      instr_known_in = instr_known_ff;
      if (accept && req.req_type == REQ_IR) begin
         last_instr_in  = req.ir_value;
         instr_known_in = 1'b1;
      end
   end

   // Clamp the configuration and the requested DR length into the ranges the stream format allows.
   always_comb begin
      ir_pre  = (ir_bits_before_ff > IR_BITS_MAX) ? IR_BITS_MAX : ir_bits_before_ff;
      ir_post = (ir_bits_after_ff > IR_BITS_MAX) ? IR_BITS_MAX : ir_bits_after_ff;
      if (ir_len_target_ff == 4'd0) begin
         ir_len = 4'd1;
      end else if (ir_len_target_ff > 4'd8) begin
         ir_len = 4'd8;
      end else begin
         ir_len = ir_len_target_ff;
      end
      dev_pre      = ({1'b0, devices_before_ff} > MAX_DEV_M1) ? MAX_DEV_M1
                                                              : {1'b0, devices_before_ff};
      dev_post_max = MAX_DEV_M1 - dev_pre;
      dev_post     = ({1'b0, devices_after_ff} > dev_post_max) ? dev_post_max
                                                               : {1'b0, devices_after_ff};
      if (req.dr_length == 6'd0) begin
         dr_len = 7'd1;
      end else if ({1'b0, req.dr_length} > DR_MAX) begin
         dr_len = DR_MAX;
      end else begin
         dr_len = {1'b0, req.dr_length};
      end
   end

   always_comb begin
      if (req.req_type == REQ_IR) begin
         cmd.head_tms   = 4'b0011;
         cmd.body_start = 3'd4;
         cmd.mid_start  = POS_W'(4) + POS_W'(ir_pre);
         cmd.mid_end    = cmd.mid_start + POS_W'(ir_len);
         cmd.body_end   = cmd.mid_end + POS_W'(ir_post);
         cmd.data       = DATA_W'(req.ir_value);
         cmd.capture    = 1'b0;
      end else begin
         cmd.head_tms   = 4'b0001;
         cmd.body_start = 3'd3;
         cmd.mid_start  = POS_W'(3) + POS_W'(dev_pre);
         cmd.mid_end    = cmd.mid_start + POS_W'(dr_len);
         cmd.body_end   = cmd.mid_end + POS_W'(dev_post);
         cmd.data       = req.dr_data;
         cmd.capture    = req.capture_data;
      end
      cmd.len_total = cmd.body_end + POS_W'(2);
   end

   assign q_push.valid = accept && !skip;
   assign q_push.cmd   = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         devices_before_ff <= '0;
         devices_after_ff  <= '0;
         ir_bits_before_ff <= '0;
         ir_len_target_ff  <= 4'd4;
         ir_bits_after_ff  <= '0;
         last_instr_ff     <= '0;
         instr_known_ff    <= 1'b0;
      end else begin
         devices_before_ff <= devices_before_in;
         devices_after_ff  <= devices_after_in;
         ir_bits_before_ff <= ir_bits_before_in;
         ir_len_target_ff  <= ir_len_target_in;
         ir_bits_after_ff  <= ir_bits_after_in;
         last_instr_ff     <= last_instr_in;
         instr_known_ff    <= instr_known_in;
      end
   end

endmodule

>>> rtl/core/jcsg_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the byte serializer.
module jcsg_queue import jcsg_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  jcsg_push_type  q_push,
   input  logic           pop,
   output jcsg_qstat_type q_stat,
   output jcsg_cmd_type   head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jcsg_cmd_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = q_push.valid && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/core/jcsg_back.sv
`timescale 1ns / 1ps
// Back end: expands one queued command into packed TMS/TDI/read-mask bytes.
module jcsg_back import jcsg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  jcsg_qstat_type q_stat,
   input  jcsg_cmd_type   head,
   output logic           pop,
   jcsg_rsp_if.source     rsp
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SHIFT = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   jcsg_cmd_type     cmd_ff, cmd_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       tms_ff, tms_in;
   logic [7:0]       tdi_ff, tdi_in;
   logic [7:0]       rd_ff, rd_in;
   logic [3:0]       count_ff, count_in;
   logic             last_ff, last_in;

   logic             out_free;
   logic             emit;
   logic [POS_W-1:0] remain;
   logic             last_byte;
   logic [7:0]       lane_tms, lane_tdi, lane_rd;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign emit      = (state_ff == ST_SHIFT) && out_free;
   assign pop       = (state_ff == ST_IDLE) && !q_stat.empty;
   assign remain    = cmd_ff.len_total - pos_ff;
   assign last_byte = (remain <= POS_W'(8));

   // Each lane classifies its own stream position independently.
   always_comb begin
      logic [POS_W-1:0] b;
      logic [POS_W-1:0] idx;
      lane_tms = '0;
      lane_tdi = '0;
      lane_rd  = '0;
      for (int j = 0; j < 8; j++) begin
         b   = pos_ff + POS_W'(j);
         idx = b - cmd_ff.mid_start;
         if (b < POS_W'(cmd_ff.body_start)) begin
            lane_tms[j] = cmd_ff.head_tms[b[1:0]];
         end else if (b < cmd_ff.body_end) begin
            lane_tms[j] = (b == cmd_ff.body_end - 1'b1);
            if (b >= cmd_ff.mid_start && b < cmd_ff.mid_end) begin
               lane_tdi[j] = (idx < POS_W'(DATA_W)) ? cmd_ff.data[idx[4:0]] : 1'b0;
               lane_rd[j]  = cmd_ff.capture;
            end else begin
               lane_tdi[j] = 1'b1;
            end
         end else if (b == cmd_ff.body_end) begin
            lane_tms[j] = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      tms_in       = tms_ff;
      tdi_in       = tdi_ff;
      rd_in        = rd_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cmd_in   = head;
               pos_in   = '0;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (emit) begin
               out_valid_in = 1'b1;
               tms_in       = lane_tms;
               tdi_in       = lane_tdi;
               rd_in        = lane_rd;
               count_in     = last_byte ? remain[3:0] : 4'd8;
               last_in      = last_byte;
               pos_in       = pos_ff + POS_W'(8);
               if (last_byte) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.tms_byte  = tms_ff;
   assign rsp.tdi_byte  = tdi_ff;
   assign rsp.read_mask = rd_ff;
   assign rsp.bit_count = count_ff;
   assign rsp.last      = last_ff;

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      pos_ff   <= pos_in;
      tms_ff   <= tms_in;
      tdi_ff   <= tdi_in;
      rd_ff    <= rd_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> rtl/core/jtag_chain_scan_generator.sv
`timescale 1ns / 1ps
// Top level of the JTAG scan sequence generator.
//
//   Port     Direction  Carries
//   req_ch   sink       IR write or DR scan request, one item per scan
//   rsp_ch   source     packed TMS/TDI/read-mask byte with bit count and last flag
//   csr_ch   sink       register index and write data, always ready
//
// A request enters the command queue in the cycle it is accepted; a repeated IR
// write is dropped there. The serializer loads a command, then emits one byte
// per cycle unless a low rsp_ch.ready stalls it: ceil((head + shifted bits + 2) / 8)
// bytes, at most 62 for an IR write and 9 for a DR scan with default parameters.
// Reset is synchronous and restores the register defaults and forgets the IR.
// A low rsp_ch.ready holds the output register; the front keeps taking
// requests until the queue fills.
module jtag_chain_scan_generator import jcsg_pkg::*; #(
   parameter int MAX_DEVICES = MAX_DEVICES_DEF,
   parameter int DR_WIDTH    = DR_WIDTH_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   jcsg_req_if.sink   req_ch,
   jcsg_rsp_if.source rsp_ch,
   jcsg_csr_if.sink   csr_ch
);

   jcsg_push_type  q_push;
   jcsg_qstat_type q_stat;
   jcsg_cmd_type   q_head;
   logic           q_pop;

   jcsg_front #(
      .MAX_DEVICES (MAX_DEVICES),
      .DR_WIDTH    (DR_WIDTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .csr    (csr_ch),
      .q_stat (q_stat),
      .q_push (q_push)
   );

   jcsg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .pop    (q_pop),
      .q_stat (q_stat),
      .head   (q_head)
   );

   jcsg_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_stat (q_stat),
      .head   (q_head),
      .pop    (q_pop),
      .rsp    (rsp_ch)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push.valid && q_stat.full))
      else $error("command pushed into a full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.bit_count != 4'd0 && rsp_ch.bit_count <= 4'd8))
      else $error("result byte with bit count out of range");

   a_full_unless_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.last) |-> rsp_ch.bit_count == 4'd8)
      else $error("partial byte before the end of a scan");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("serializer loaded from an empty queue");

endmodule

>>> verif/jcsg_scan_checker.sv
`timescale 1ns / 1ps
// Scoreboard: expands each accepted request into its scan bytes and checks the result channel.
module jcsg_scan_checker import jcsg_pkg::*; (
   input  logic clock,
   input  logic reset,
   jcsg_req_if  req_ch,
   jcsg_rsp_if  rsp_ch,
   jcsg_csr_if  csr_ch,
   output int   mismatch_count,
   output int   bytes_pending,
   output int   bytes_checked,
   output int   scans_expanded,
   output int   ir_repeats
);

   typedef struct packed {
      logic [7:0] tms;
      logic [7:0] tdi;
      logic [7:0] mask;
      logic [3:0] count;
      logic       last;
   } scan_byte_type;

   scan_byte_type scan_bytes_due [$];

   // Shadow copy of the chain description.
   logic [4:0] devices_before;
   logic [4:0] devices_after;
   logic [7:0] ir_bits_before;
   logic [3:0] ir_len_target;
   logic [7:0] ir_bits_after;

   logic [7:0] last_ir;
   logic       ir_known;

   // Byte being packed, LSB first.
   logic [7:0] acc_tms;
   logic [7:0] acc_tdi;
   logic [7:0] acc_mask;
   int         acc_bits;

   task automatic close_byte(input int n);
      scan_byte_type b;
      b.tms   = acc_tms;
      b.tdi   = acc_tdi;
      b.mask  = acc_mask;
      b.count = 4'(n);
      b.last  = 1'b0;
      scan_bytes_due.push_back(b);
      acc_tms  = '0;
      acc_tdi  = '0;
      acc_mask = '0;
      acc_bits = 0;
   endtask

   task automatic shift_bit(input logic tms, input logic tdi, input logic rd);
      acc_tms[acc_bits]  = tms;
      acc_tdi[acc_bits]  = tdi;
      acc_mask[acc_bits] = rd;
      acc_bits++;
      if (acc_bits == 8) close_byte(8);
   endtask

   task automatic expand_scan(input logic kind, input logic [7:0] ir,
                              input logic [DATA_W-1:0] data, input logic [5:0] length,
                              input logic capture);
      int   first_byte;
      int   lead;
      int   body;
      int   tail;
      int   total;
      logic in_target;
      first_byte = scan_bytes_due.size();
      acc_tms    = '0;
      acc_tdi    = '0;
      acc_mask   = '0;
      acc_bits   = 0;
      if (kind == REQ_IR) begin
         if (ir_known && last_ir == ir) begin
            ir_repeats++;
            return;
         end
         last_ir  = ir;
         ir_known = 1'b1;
         lead  = (ir_bits_before > IR_BITS_MAX) ? IR_BITS_MAX : ir_bits_before;
         body  = (ir_len_target == 0) ? 1 : (ir_len_target > 8) ? 8 : ir_len_target;
         tail  = (ir_bits_after > IR_BITS_MAX) ? IR_BITS_MAX : ir_bits_after;
         total = lead + body + tail;
         // Idle to Shift-IR goes through Select-DR, Select-IR and Capture-IR.
         for (int i = 0; i < 4; i++) shift_bit(i < 2, 1'b0, 1'b0);
         for (int i = 0; i < total; i++) begin
            in_target = (i >= lead) && (i < lead + body);
            shift_bit(i == total - 1, in_target ? ir[i - lead] : 1'b1, 1'b0);
         end
      end else begin
         lead  = (devices_before > MAX_DEVICES_DEF - 1) ? MAX_DEVICES_DEF - 1 : devices_before;
         tail  = (int'(devices_after) > MAX_DEVICES_DEF - 1 - lead) ?
                 MAX_DEVICES_DEF - 1 - lead : devices_after;
         body  = (length == 0) ? 1 : (length > DR_WIDTH_DEF) ? DR_WIDTH_DEF : length;
         total = lead + body + tail;
         for (int i = 0; i < 3; i++) shift_bit(i == 0, 1'b0, 1'b0);
         for (int i = 0; i < total; i++) begin
            in_target = (i >= lead) && (i < lead + body);
            shift_bit(i == total - 1, in_target ? data[i - lead] : 1'b1,
                      in_target & capture);
         end
      end
      // Update, then back to Run-Test/Idle.
      shift_bit(1'b1, 1'b0, 1'b0);
      shift_bit(1'b0, 1'b0, 1'b0);
      if (acc_bits > 0) close_byte(acc_bits);
      if (scan_bytes_due.size() > first_byte)
         scan_bytes_due[scan_bytes_due.size() - 1].last = 1'b1;
      scans_expanded++;
   endtask

   task automatic report_bad(input string why, input scan_byte_type want,
                             input scan_byte_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s (expected/actual): tms %02h/%02h tdi %02h/%02h mask %02h/%02h",
                  $time, why, want.tms, got.tms, want.tdi, got.tdi, want.mask, got.mask,
                  "  count %0d/%0d last %0b/%0b", want.count, got.count, want.last, got.last);
   endtask

   always @(posedge clock) begin : watch
      scan_byte_type want;
      scan_byte_type got;
      if (reset) begin
         devices_before = '0;
         devices_after  = '0;
         ir_bits_before = '0;
         ir_len_target  = 4'd4;
         ir_bits_after  = '0;
         last_ir        = '0;
         ir_known       = 1'b0;
         scan_bytes_due.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_DEVICES_BEFORE: devices_before = csr_ch.data[4:0];
               CSR_DEVICES_AFTER:  devices_after  = csr_ch.data[4:0];
               CSR_IR_BITS_BEFORE: ir_bits_before = csr_ch.data;
               CSR_IR_LEN_TARGET:  ir_len_target  = csr_ch.data[3:0];
               CSR_IR_BITS_AFTER:  ir_bits_after  = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            expand_scan(req_ch.req_type, req_ch.ir_value, req_ch.dr_data,
                        req_ch.dr_length, req_ch.capture_data);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.tms_byte, rsp_ch.tdi_byte, rsp_ch.read_mask,
                   rsp_ch.bit_count, rsp_ch.last};
            if (scan_bytes_due.size() == 0) begin
               report_bad("byte with none due", '0, got);
            end else begin
               want = scan_bytes_due.pop_front();
               if (got !== want) report_bad("wrong scan byte", want, got);
               bytes_checked++;
            end
         end
      end
      bytes_pending = scan_bytes_due.size();
   end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the JTAG scan sequence generator; checking lives in jcsg_scan_checker.
module testbench;
   import jcsg_pkg::*;

   localparam int PHASES         = 7;
   localparam int PHASE_SCANS    = 42;
   localparam int DRAIN_CYCLES   = 16;
   localparam int LONG_HOLD      = 400;
   // Longest quiet stretch in a correct run is the long receiver hold; the limit sits above it.
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   jcsg_req_if req_ch ();
   jcsg_rsp_if rsp_ch ();
   jcsg_csr_if csr_ch ();

   int mismatch_count;
   int bytes_pending;
   int bytes_checked;
   int scans_expanded;
   int ir_repeats;

   int         req_max_gap   = 17;
   int         rsp_max_stall = 17;
   bit         hold_rsp      = 1'b0;
   logic [7:0] last_ir_sent  = '0;
   bit         ir_sent       = 1'b0;

   jtag_chain_scan_generator u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   jcsg_scan_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending),
      .bytes_checked  (bytes_checked),
      .scans_expanded (scans_expanded),
      .ir_repeats     (ir_repeats)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_req(input logic kind, input logic [7:0] ir, input logic [DATA_W-1:0] data,
                           input logic [5:0] length, input logic capture);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= kind;
      req_ch.ir_value     <= ir;
      req_ch.dr_data      <= data;
      req_ch.dr_length    <= length;
      req_ch.capture_data <= capture;
      do @(posedge clock); while (!req_ch.ready);
      if (kind == REQ_IR) begin
         last_ir_sent = ir;
         ir_sent      = 1'b1;
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [7:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // Waits until every predicted byte has come out, then lets the serializer settle.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (bytes_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_settings(input int phase);
      // Packed as {ir_bits_after, ir_len_target, ir_bits_before, devices_after, devices_before}.
      logic [4:0][7:0] cfg;
      case (phase)
         // Every field but the IR length at or past its top: counts and IR totals saturate, IR length 0 acts as 1.
         0: cfg = {8'd255, 8'd0, 8'd255, 8'd31, 8'd31};
         1: cfg = {8'd240, 8'd8, 8'd0, 8'd31, 8'd0};
         2: cfg = {8'd0, 8'd15, 8'd240, 8'd0, 8'd1};
         default: begin
            cfg = {8'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255))};
         end
      endcase
      write_reg(CSR_DEVICES_BEFORE, cfg[0]);
      write_reg(CSR_DEVICES_AFTER, cfg[1]);
      write_reg(CSR_IR_BITS_BEFORE, cfg[2]);
      write_reg(CSR_IR_LEN_TARGET, cfg[3]);
      write_reg(CSR_IR_BITS_AFTER, cfg[4]);
      // Unassigned indexes must be ignored.
      for (int idx = CSR_IR_BITS_AFTER + 1; idx < 2 ** CSR_IDX_W; idx++)
         write_reg(CSR_IDX_W'(idx), 8'($urandom_range(0, 255)));
      csr_ch.valid <= 1'b0;
   endtask

   // Receiver: a random stall before each item, plus one long hold on request.
   initial begin : rsp_side
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = $urandom_range(0, rsp_max_stall);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timed out: nothing moved for %0d cycles", WATCHDOG_LIMIT);
      $display("jtag_chain_scan_generator: mismatch");
      $finish;
   end

   initial begin : stimulus
      int         scans;
      logic [7:0] ir;
      logic [5:0] length;
      int         pick;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_IR;
      req_ch.ir_value     = '0;
      req_ch.dr_data      = '0;
      req_ch.dr_length    = '0;
      req_ch.capture_data = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = CSR_DEVICES_BEFORE;
      csr_ch.data         = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset chain. The first IR write of zero is not a repeat,
      // since nothing has been written yet.
      send_req(REQ_IR, 8'h00, $urandom, 6'($urandom), 1'b1);
      send_req(REQ_IR, 8'h00, $urandom, 6'($urandom), 1'b0);
      send_req(REQ_DR, 8'($urandom), 32'h0000_0000, 6'd1, 1'b0);
      send_req(REQ_DR, 8'($urandom), 32'hFFFF_FFFF, 6'd32, 1'b1);
      send_req(REQ_DR, 8'($urandom), 32'h0000_0001, 6'd0, 1'b1);
      send_req(REQ_DR, 8'($urandom), 32'hAAAA_AAAA, 6'd33, 1'b0);
      send_req(REQ_DR, 8'($urandom), 32'h5555_5555, 6'd63, 1'b1);
      send_req(REQ_IR, 8'hFF, $urandom, 6'($urandom), 1'b0);
      send_req(REQ_IR, 8'hFF, $urandom, 6'($urandom), 1'b1);
      send_req(REQ_IR, 8'h5A, $urandom, 6'($urandom), 1'b0);
      send_req(REQ_DR, 8'($urandom), 32'h0000_005A, 6'd8, 1'b1);
      send_req(REQ_DR, 8'($urandom), 32'h0000_0000, 6'd32, 1'b0);
      send_req(REQ_IR, 8'hA5, $urandom, 6'($urandom), 1'b1);
      send_req(REQ_DR, 8'($urandom), 32'h0000_001F, 6'd5, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         program_settings(phase);
         req_max_gap   = (phase == 1 || phase == 4) ? 0 : 17;
         rsp_max_stall = (phase == 3 || phase == 6) ? 0 : 17;
         // Fill the block while the receiver sits still for a long while.
         if (phase == 1) hold_rsp = 1'b1;
         // A register write leaves the remembered instruction alone, so this one is dropped.
         send_req(REQ_IR, last_ir_sent, $urandom, 6'($urandom), 1'($urandom));
         scans = 0;
         while (scans < PHASE_SCANS) begin
            if ($urandom_range(0, 99) < 55) begin
               pick   = $urandom_range(0, 19);
               length = (pick == 0) ? 6'd0 :
                        (pick == 1) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(1, 32));
               send_req(REQ_DR, 8'($urandom), $urandom, length, 1'($urandom));
               scans++;
            end else begin
               ir = ($urandom_range(0, 3) == 0) ? last_ir_sent : 8'($urandom_range(0, 255));
               if (!(ir_sent && ir == last_ir_sent)) scans++;
               send_req(REQ_IR, ir, $urandom, 6'($urandom), 1'($urandom));
            end
         end
      end
      settle();

      $display("Checked %0d scan bytes from %0d expanded requests; %0d repeated IR writes dropped.",
               bytes_checked, scans_expanded, ir_repeats);
      $display("Chain settings used: %0d, from the reset chain to saturating counts and IR sizes.",
               PHASES + 1);
      if (mismatch_count == 0 && bytes_pending == 0)
         $display("jtag_chain_scan_generator: match");
      else
         $display("jtag_chain_scan_generator: mismatch");
      $finish;
   end

endmodule
